### hw/rtl/scpc_pkg.sv
// Package for the set-associative clock-replacement cache policy block.
// Holds the fixed field widths and the default geometry; no dependencies.
package scpc_pkg;

  // Fixed widths of the item fields.
  localparam int SECTOR_W     = 32;
  localparam int OFFSET_W     = 9;
  localparam int OUT_WAY_W    = 2;
  localparam int CACHE_ADDR_W = 15;

  // Default cache geometry.
  localparam int SETS_DEF       = 16;
  localparam int WAYS_DEF       = 4;
  localparam int BLOCK_BITS_DEF = 9;

endpackage

### hw/rtl/set_assoc_clock_cache_policy_top.sv
// Top level of the set-associative write-back cache policy with clock replacement.
// Depends on scpc_pkg; holds the tag memory and the per-set metadata memory.
//
// Channel  | Direction | Handshake                  | Ports
// ---------+-----------+----------------------------+-----------------------------------------
// input    | in        | start high while busy low  | in_mode, in_sector_addr, in_byte_offset
// result   | out       | out_valid, one-cycle pulse | out_hit, out_way, out_destage,
//          |           |                            | out_victim_sector, out_cache_addr
//
// With a power-of-two SETS the accepting cycle reads the set's row from both memories and
// ST_UPD decides and writes the row back. Other SETS first pass through ST_QUO for the
// reciprocal multiply and ST_RD, which forms the set index and reads the row. The result
// pulse follows ST_UPD, when busy is already low, so the next item may be accepted with it.
// Reset is synchronous; it clears control and the per-set valid flags, with no clearing pass.
// The receiver cannot stall, so results are never held back.
module set_assoc_clock_cache_policy_top
  import scpc_pkg::*;
#(
  parameter int SETS       = SETS_DEF,
  parameter int WAYS       = WAYS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [SECTOR_W-1:0]     in_sector_addr,
  input  logic [OFFSET_W-1:0]     in_byte_offset,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [OUT_WAY_W-1:0]    out_way,
  output logic                    out_destage,
  output logic [SECTOR_W-1:0]     out_victim_sector,
  output logic [CACHE_ADDR_W-1:0] out_cache_addr
);

  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W    = (SETS * WAYS > 1) ? $clog2(SETS * WAYS) : 1;
  localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  // Exact reciprocal for the set index: q = (x * RECIP) >> RECIP_SH.
  localparam int RECIP_SH  = SECTOR_W + $clog2(SETS);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SH) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [SECTOR_W:0] RECIP = RECIP_FULL[SECTOR_W:0];

  typedef enum logic [1:0] {ST_IDLE, ST_QUO, ST_RD, ST_UPD} state_t;

  typedef struct packed {
    logic [WAYS-1:0]  vmask;
    logic [WAYS-1:0]  rmask;
    logic [WAYS-1:0]  dmask;
    logic [WAY_W-1:0] hand;
  } meta_t;

  typedef logic [WAYS-1:0][SECTOR_W-1:0] tag_row_t;

  // Way reached from s after i steps of the clock hand.
  function automatic logic [WAY_W-1:0] way_at(input logic [WAY_W-1:0] s,
                                              input int unsigned i);
    logic [WAY_W:0] t;
    t = {1'b0, s} + (WAY_W+1)'(i);
    if (t >= (WAY_W+1)'(WAYS)) begin
      t = t - (WAY_W+1)'(WAYS);
    end
    return t[WAY_W-1:0];
  endfunction

  // Storage.
  tag_row_t        tag_mem [SETS];
  meta_t           meta_mem [SETS];
  logic [SETS-1:0] meta_vld_r;

  // Control and captured item.
  state_t                 state_r, state_nxt;
  logic                   mode_r;
  logic [SECTOR_W-1:0]    sector_r;
  logic [BLOCK_BITS-1:0]  offs_r;
  logic [SET_W-1:0]       set_r;
  logic [SECTOR_W-1:0]    q_r;
  logic [2*SECTOR_W:0]    q_prod;

  // Read port.
  logic                   accept;
  logic                   rd_en;
  logic [SET_W-1:0]       rd_set;
  logic [SET_W-1:0]       set_low;
  logic [SET_W-1:0]       set_calc;
  tag_row_t               tag_rd_r;
  meta_t                  meta_rd_r;
  logic                   rd_vld_r;

  // Decision logic.
  meta_t                  meta_cur;
  meta_t                  meta_wr;
  tag_row_t               tag_wr;
  logic                   tag_we;
  logic [WAYS-1:0]        match;
  logic                   hit;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       first_way;
  logic [WAY_W-1:0]       w;
  logic                   found1, found2;
  logic [WAY_W-1:0]       way1, way2;
  logic [WAYS-1:0]        ref_clr1;
  logic [WAYS-1:0]        ref_swept;
  logic [WAY_W-1:0]       victim_way;
  logic [WAY_W-1:0]       sel_way;
  logic [WAYS-1:0]        sel_bit;
  logic                   destage;
  logic [LINE_W-1:0]      line_idx;

  // Output registers.
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [OUT_WAY_W-1:0]    out_way_r;
  logic                    out_destage_r;
  logic [SECTOR_W-1:0]     out_victim_r;
  logic [CACHE_ADDR_W-1:0] out_caddr_r;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Set index: low bits for a power-of-two set count, else x - q*SETS.
  assign set_low  = SET_W'(in_sector_addr & SECTOR_W'(SETS - 1));
  assign q_prod   = {{(SECTOR_W+1){1'b0}}, sector_r} * {{SECTOR_W{1'b0}}, RECIP};
  assign set_calc = SET_W'(sector_r - q_r * SECTOR_W'(SETS));

  assign rd_en  = (accept && SETS_POW2) || (state_r == ST_RD);
  assign rd_set = (state_r == ST_RD) ? set_calc : set_low;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = SETS_POW2 ? ST_UPD : ST_QUO;
        end
      end
      ST_QUO:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hit search and clock sweep over the set read from memory.
  always_comb begin
    meta_cur = rd_vld_r ? meta_rd_r : '0;

    // Valid tags in a set are unique, so the hit way does not depend on search order.
    hit     = 1'b0;
    hit_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = meta_cur.vmask[i] && (tag_rd_r[i] == sector_r);
      if (match[i]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
    end

    // A write steps the hand before looking, a read looks first.
    first_way = mode_r ? way_at(meta_cur.hand, 1) : meta_cur.hand;

    // First pass: clean and unreferenced, clearing reference bits on the way.
    found1   = 1'b0;
    way1     = '0;
    ref_clr1 = '0;
    for (int i = 0; i < WAYS; i++) begin
      w = way_at(first_way, i);
      if (!found1) begin
        if (!meta_cur.dmask[w] && !meta_cur.rmask[w]) begin
          found1 = 1'b1;
          way1   = w;
        end else begin
          ref_clr1[w] = 1'b1;
        end
      end
    end

    // Second pass: all reference bits are clear, so any clean way qualifies.
    found2 = 1'b0;
    way2   = '0;
    for (int i = 0; i < WAYS; i++) begin
      w = way_at(first_way, i);
      if (!found2 && !meta_cur.dmask[w]) begin
        found2 = 1'b1;
        way2   = w;
      end
    end

    // Every way dirty: the way after the hand is written back and refilled.
    victim_way = way_at(meta_cur.hand, 1);
    destage    = !hit && !found1 && !found2;

    if (hit) begin
      sel_way   = hit_way;
      ref_swept = meta_cur.rmask;
    end else if (found1) begin
      sel_way   = way1;
      ref_swept = meta_cur.rmask & ~ref_clr1;
    end else begin
      sel_way   = found2 ? way2 : victim_way;
      ref_swept = '0;
    end

    sel_bit = '0;
    sel_bit[sel_way] = 1'b1;

    // Updated metadata row.
    meta_wr.vmask = meta_cur.vmask | (hit ? '0 : sel_bit);
    meta_wr.rmask = ref_swept | sel_bit;
    meta_wr.dmask = (meta_cur.dmask & ~(destage ? sel_bit : '0)) | (mode_r ? sel_bit : '0);
    meta_wr.hand  = sel_way;

    // Updated tag row on a fill.
    tag_wr          = tag_rd_r;
    tag_wr[sel_way] = sector_r;
    tag_we          = (state_r == ST_UPD) && !hit;

    line_idx = LINE_W'(set_r) * LINE_W'(WAYS) + LINE_W'(sel_way);
  end

  // Tag memory: one row per set.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_rd_r <= tag_mem[rd_set];
    end
    if (tag_we) begin
      tag_mem[set_r] <= tag_wr;
    end
  end

  // Metadata memory: valid, reference and dirty masks plus the clock hand.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      meta_rd_r <= meta_mem[rd_set];
    end
    if (state_r == ST_UPD) begin
      meta_mem[set_r] <= meta_wr;
    end
  end

  // Per-set flags: a set never written reads as the reset metadata.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= meta_vld_r[rd_set];
      end
      if (state_r == ST_UPD) begin
        meta_vld_r[set_r] <= 1'b1;
      end
    end
  end

  // State, captured item and registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_UPD);
      if (accept) begin
        mode_r   <= in_mode;
        sector_r <= in_sector_addr;
        offs_r   <= BLOCK_BITS'(in_byte_offset);
        set_r    <= set_low;
      end
      if (state_r == ST_QUO) begin
        q_r <= SECTOR_W'(q_prod >> RECIP_SH);
      end
      if (state_r == ST_RD) begin
        set_r <= set_calc;
      end
      if (state_r == ST_UPD) begin
        out_hit_r     <= hit;
        out_way_r     <= OUT_WAY_W'(sel_way);
        out_destage_r <= destage;
        out_victim_r  <= destage ? tag_rd_r[victim_way] : '0;
        out_caddr_r   <= CACHE_ADDR_W'({line_idx, offs_r});
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_way           = out_way_r;
  assign out_destage       = out_destage_r;
  assign out_victim_sector = out_victim_r;
  assign out_cache_addr    = out_caddr_r;

endmodule

### hw/rtl/scpc_checker.sv
// Port-level checks for the cache policy top level, attached by a bind below.
// Depends on scpc_pkg and on set_assoc_clock_cache_policy_top.
module scpc_checker
  import scpc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    in_mode,
  input logic [SECTOR_W-1:0]     in_sector_addr,
  input logic [OFFSET_W-1:0]     in_byte_offset,
  input logic                    out_valid,
  input logic                    out_hit,
  input logic [OUT_WAY_W-1:0]    out_way,
  input logic                    out_destage,
  input logic [SECTOR_W-1:0]     out_victim_sector,
  input logic [CACHE_ADDR_W-1:0] out_cache_addr
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after an accepted item");

  // Each item ends in ST_UPD and then the block is idle, so result pulses never touch.
  a_pulse_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result pulses in a row");

  // A victim sector is reported only with a destage.
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_destage |-> out_victim_sector == '0)
    else $error("victim sector without destage");

  // A hit never evicts.
  a_hit_no_destage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_destage)
    else $error("destage reported on a hit");

endmodule

bind set_assoc_clock_cache_policy_top scpc_checker u_scpc_checker (.*);

### sim/scpc_access_checker.sv
// Checker for the clock-replacement cache policy block: predicts each access decision
// and compares it with the result channel. Depends on scpc_pkg for field widths and geometry.
module scpc_access_checker
  import scpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_mode,
  input  logic [SECTOR_W-1:0]     in_sector_addr,
  input  logic [OFFSET_W-1:0]     in_byte_offset,
  input  logic                    out_valid,
  input  logic                    out_hit,
  input  logic [OUT_WAY_W-1:0]    out_way,
  input  logic                    out_destage,
  input  logic [SECTOR_W-1:0]     out_victim_sector,
  input  logic [CACHE_ADDR_W-1:0] out_cache_addr,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int SETS       = SETS_DEF;
  localparam int WAYS       = WAYS_DEF;
  localparam int BLOCK_BITS = BLOCK_BITS_DEF;

  typedef struct packed {
    logic                    hit;
    logic [OUT_WAY_W-1:0]    way;
    logic                    destage;
    logic [SECTOR_W-1:0]     victim;
    logic [CACHE_ADDR_W-1:0] cache_addr;
  } decision_t;

  // Shadow copy of the policy state.
  logic [SECTOR_W-1:0] tag_mem       [SETS][WAYS];
  logic [WAYS-1:0]     valid_bits    [SETS];
  logic [WAYS-1:0]     accessed_bits [SETS];
  logic [WAYS-1:0]     modified_bits [SETS];
  int                  hand_pos      [SETS];

  decision_t expected_decisions[$];

  task automatic clear_policy();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) tag_mem[s][w] = '1;
      valid_bits[s]    = '0;
      accessed_bits[s] = '0;
      modified_bits[s] = '0;
      hand_pos[s]      = 0;
    end
  endtask

  // Works out the decision for one access and updates the shadow state.
  // A read looks at the hand and then advances it; a write advances first.
  task automatic decide_access(input logic is_write, input logic [SECTOR_W-1:0] sector,
                               input logic [OFFSET_W-1:0] offs, output decision_t d);
    int          set;
    int          hand;
    logic        hit;
    logic        found;
    logic        destage;
    logic [31:0] victim;
    logic [31:0] caddr;
    set     = int'(sector % SETS);
    hand    = hand_pos[set] % WAYS;
    hit     = 1'b0;
    found   = 1'b0;
    destage = 1'b0;
    victim  = '0;

    // Hit search over every way of the set.
    for (int i = 0; i < WAYS; i++) begin
      if (is_write) hand = (hand + 1) % WAYS;
      if (valid_bits[set][hand] && tag_mem[set][hand] == sector) begin
        hit = 1'b1;
        break;
      end
      if (!is_write) hand = (hand + 1) % WAYS;
    end

    // Clock sweep: first clean, unreferenced way; reference bits are cleared on the way.
    if (!hit) begin
      for (int i = 0; i < 2 * WAYS; i++) begin
        if (is_write) hand = (hand + 1) % WAYS;
        if (!modified_bits[set][hand] && !accessed_bits[set][hand]) begin
          found = 1'b1;
          break;
        end
        accessed_bits[set][hand] = 1'b0;
        if (!is_write) hand = (hand + 1) % WAYS;
      end
      // Every way is dirty, so the one after the hand is written back and refilled.
      if (!found) begin
        hand    = (hand + 1) % WAYS;
        destage = 1'b1;
        victim  = tag_mem[set][hand];
        modified_bits[set][hand] = 1'b0;
      end
      tag_mem[set][hand]    = sector;
      valid_bits[set][hand] = 1'b1;
    end

    accessed_bits[set][hand] = 1'b1;
    if (is_write) modified_bits[set][hand] = 1'b1;
    hand_pos[set] = hand;

    caddr = ((set * WAYS + hand) << BLOCK_BITS) + (offs & ((1 << BLOCK_BITS) - 1));
    d.hit        = hit;
    d.way        = OUT_WAY_W'(hand);
    d.destage    = destage;
    d.victim     = destage ? victim : '0;
    d.cache_addr = caddr[CACHE_ADDR_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Results are compared first, since a result may leave in the cycle that accepts
  // the next item.
  always @(posedge clk) begin
    decision_t want;
    decision_t next_want;
    if (!rst_n) begin
      clear_policy();
      expected_decisions.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_valid) begin
        if (expected_decisions.size() == 0) begin
          $display("%0t: unexpected result, hit %0b way %0d cache_addr %0h", $time,
                   out_hit, out_way, out_cache_addr);
          mismatches++;
        end else begin
          want = expected_decisions.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("way", 32'(want.way), 32'(out_way));
          check_field("destage", 32'(want.destage), 32'(out_destage));
          check_field("victim_sector", want.victim, out_victim_sector);
          check_field("cache_addr", 32'(want.cache_addr), 32'(out_cache_addr));
        end
      end
      if (start && !busy) begin
        decide_access(in_mode, in_sector_addr, in_byte_offset, next_want);
        expected_decisions.push_back(next_want);
      end
      outstanding = expected_decisions.size();
    end
  end

endmodule

### sim/set_assoc_clock_cache_policy_top_test.sv
// Testbench top for the clock-replacement cache policy block: drives directed and random
// accesses and gives the verdict. Depends on scpc_pkg, the block and scpc_access_checker.
module set_assoc_clock_cache_policy_top_test;
  import scpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_SIZE      = 24;
  localparam int PHASE_ITEMS    = 150;
  localparam int TAIL_CYCLES    = 20;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_mode = 1'b0;
  logic [SECTOR_W-1:0]     in_sector_addr = '0;
  logic [OFFSET_W-1:0]     in_byte_offset = '0;
  logic                    out_valid;
  logic                    out_hit;
  logic [OUT_WAY_W-1:0]    out_way;
  logic                    out_destage;
  logic [SECTOR_W-1:0]     out_victim_sector;
  logic [CACHE_ADDR_W-1:0] out_cache_addr;
  int                      mismatches;
  int                      outstanding;
  int                      stall_cycles = 0;

  logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];

  set_assoc_clock_cache_policy_top dut (.*);

  scpc_access_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one item at a falling edge and holds it until the block takes it.
  task automatic send_item(input logic is_write, input logic [SECTOR_W-1:0] sector,
                           input logic [OFFSET_W-1:0] offs, input int idle_pct);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start          = 1'b1;
    in_mode        = is_write;
    in_sector_addr = sector;
    in_byte_offset = offs;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // A few sets share many sectors, so hits, clean refills and destages all occur.
  task automatic refresh_pool();
    logic [3:0] hot_sets [3];
    for (int i = 0; i < 3; i++) hot_sets[i] = 4'($urandom_range(15));
    for (int i = 0; i < POOL_SIZE; i++) begin
      sector_pool[i] = ($urandom() & 32'hFFFF_FFF0) | 32'(hot_sets[i % 3]);
    end
    sector_pool[0] = '1;
  endtask

  function automatic logic [SECTOR_W-1:0] pick_sector();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return sector_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  task automatic run_phase(input int items, input int idle_pct);
    refresh_pool();
    for (int k = 0; k < items; k++) begin
      send_item(1'($urandom_range(1)), pick_sector(), 9'($urandom_range(511)), idle_pct);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // All-ones sector on a never-filled set must miss, then hit once filled.
    send_item(1'b0, 32'hFFFF_FFFF, 9'h000, 0);
    send_item(1'b0, 32'hFFFF_FFFF, 9'h1FF, 0);
    // Write miss, read hit and write hit in set zero.
    send_item(1'b1, 32'h0000_0000, 9'h1FF, 0);
    send_item(1'b0, 32'h0000_0000, 9'h000, 0);
    send_item(1'b1, 32'h0000_0000, 9'h100, 0);
    // Fill the rest of set zero with dirty ways, then miss on write and read to force destages.
    send_item(1'b1, 32'h0000_0010, 9'h001, 0);
    send_item(1'b1, 32'h0000_0020, 9'h002, 0);
    send_item(1'b1, 32'h0000_0030, 9'h004, 0);
    send_item(1'b1, 32'h0000_0040, 9'h008, 0);
    send_item(1'b0, 32'h0000_0050, 9'h010, 0);
    // Clean reads overflowing set one, so the sweep clears reference bits.
    send_item(1'b0, 32'h1234_5671, 9'h020, 0);
    send_item(1'b0, 32'h2234_5671, 9'h040, 0);
    send_item(1'b0, 32'h3234_5671, 9'h080, 0);
    send_item(1'b0, 32'h4234_5671, 9'h0FF, 0);
    send_item(1'b0, 32'h5234_5671, 9'h155, 0);
    send_item(1'b0, 32'h1234_5671, 9'h0AA, 0);
    // Alternating bit patterns on the sector and offset.
    send_item(1'b1, 32'hAAAA_AAAA, 9'h1AA, 0);
    send_item(1'b0, 32'h5555_5555, 9'h155, 0);
    wait_drained();

    // Random phases: back to back, heavy gaps, light gaps, then back to back again.
    run_phase(PHASE_ITEMS, 0);
    wait_drained();
    run_phase(PHASE_ITEMS, 62);
    wait_drained();
    run_phase(PHASE_ITEMS, 20);
    wait_drained();
    run_phase(PHASE_ITEMS, 0);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### set_assoc_clock_cache_policy_top.f
hw/rtl/scpc_pkg.sv
hw/rtl/set_assoc_clock_cache_policy_top.sv
hw/rtl/scpc_checker.sv
sim/scpc_access_checker.sv
sim/set_assoc_clock_cache_policy_top_test.sv
